@@ hw/rtl/aes_pkg.sv @@
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned RegIdxW = 1;
	localparam int unsigned CfgDataW = 64;
	localparam logic [RegIdxW-1:0] RegKeyHi = 1'b0;
	localparam logic [RegIdxW-1:0] RegKeyLo = 1'b1;

	typedef logic [127:0] block_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		unique case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte k of a block sits in bits 127-8k downto 120-8k.
	function automatic logic [7:0] byte_at(input block_t s, input int k);
		return s[127-8*k -: 8];
	endfunction

endpackage

@@ hw/rtl/aes_stream_if.sv @@
interface aes_stream_if;
	logic        valid;
	logic        ready;
	logic [63:0] hi;
	logic [63:0] lo;
	modport source (output valid, output hi, output lo, input ready);
	modport sink (input valid, input hi, input lo, output ready);
endinterface

@@ hw/rtl/aes_key_round.sv @@
// One step of the key expansion: round key r from round key r-1.
module aes_key_round (
	input  logic [3:0]      rnd,
	input  aes_pkg::block_t key_in,
	output aes_pkg::block_t key_out
);
	logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
	always_comb begin
		{w0, w1, w2, w3} = key_in;
		t = {aes_pkg::sbox(w3[23:16]), aes_pkg::sbox(w3[15:8]),
			aes_pkg::sbox(w3[7:0]), aes_pkg::sbox(w3[31:24])};
		t[31:24] = t[31:24] ^ aes_pkg::rcon(rnd);
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		key_out = {n0, n1, n2, n3};
	end
endmodule

@@ hw/rtl/aes_round.sv @@
// One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round #(
	parameter bit LastRound = 1'b0
) (
	input  aes_pkg::block_t state_in,
	input  aes_pkg::block_t rkey,
	output aes_pkg::block_t state_out
);
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a0, a1, a2, a3, all;
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c+r] = aes_pkg::sbox(aes_pkg::byte_at(state_in, 4*((c+r)%4)+r));
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			if (LastRound) begin
				m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
			end else begin
				m[4*c]   = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
				m[4*c+1] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
				m[4*c+2] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
				m[4*c+3] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
			end
		end
		for (int k = 0; k < 16; k++) begin
			state_out[127-8*k -: 8] = m[k] ^ aes_pkg::byte_at(rkey, k);
		end
	end
endmodule

@@ hw/rtl/aes128_block_encrypt.sv @@
// AES-128 block encryption, fully unrolled pipeline.
// Channels: blocks enter on the in channel (hi = bytes 0..7, byte 0 in the top
// bits, lo = bytes 8..15) and ciphertext leaves on out in the same layout.
// A beat is taken when valid and ready are both high.
// The key is written through the plain write port: index 0 is key_hi,
// index 1 is key_lo; other indexes are ignored. A key change takes effect for
// blocks accepted after the write; write only while the pipeline is empty.
// Ten register stages, the first loaded by the accepting edge; the ciphertext
// is offered from the last stage, which drives out.valid.
// Throughput: one block per cycle unless the receiver stalls. Each of the ten
// rounds has its own stage, with the matching round key expanded in that stage.
// Reset clears the key to zero and all stage valid bits.
// When the receiver stalls the whole pipeline holds; in.ready follows
// out.ready, or is high when the last stage is empty, so nothing is lost.
module aes128_block_encrypt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [aes_pkg::RegIdxW-1:0]  cfg_idx,
	input  logic [aes_pkg::CfgDataW-1:0] cfg_data,
	aes_stream_if.sink                   in,
	aes_stream_if.source                 out
);
	localparam int unsigned Rounds = aes_pkg::NumRounds;

	logic [63:0] key_hi_q, key_lo_q;
	logic advance;

	// The input after the initial AddRoundKey feeds the first round (combinational).
	aes_pkg::block_t st_in;
	aes_pkg::block_t rk_in;
	aes_pkg::block_t st [1:Rounds];
	aes_pkg::block_t rk [1:Rounds];
	logic vld [1:Rounds];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				aes_pkg::RegKeyHi: key_hi_q <= cfg_data;
				aes_pkg::RegKeyLo: key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = out.ready || !vld[Rounds];
	assign in.ready = advance;
	assign st_in = {in.hi, in.lo} ^ {key_hi_q, key_lo_q};
	assign rk_in = {key_hi_q, key_lo_q};

	for (genvar i = 1; i <= Rounds; i++) begin : g_stage
		aes_pkg::block_t st_prev, rk_prev, st_nx, rk_nx;
		logic vld_prev;
		if (i == 1) begin : g_head
			assign st_prev = st_in;
			assign rk_prev = rk_in;
			assign vld_prev = in.valid;
		end else begin : g_tail
			assign st_prev = st[i-1];
			assign rk_prev = rk[i-1];
			assign vld_prev = vld[i-1];
		end
		aes_key_round u_key (
			.rnd(4'(i)), .key_in(rk_prev), .key_out(rk_nx)
		);
		aes_round #(.LastRound(i == Rounds)) u_round (
			.state_in(st_prev), .rkey(rk_nx), .state_out(st_nx)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i] <= 1'b0;
			end else if (advance) begin
				vld[i] <= vld_prev;
			end
		end
		always_ff @(posedge clk) begin
			if (advance && vld_prev) begin
				st[i] <= st_nx;
				rk[i] <= rk_nx;
			end
		end
	end

	assign out.valid = vld[Rounds];
	assign out.hi = st[Rounds][127:64];
	assign out.lo = st[Rounds][63:0];

	// A stalled output beat must hold its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.hi) && $stable(out.lo))
		else $error("output beat changed while stalled");
	// The input side must stall whenever the output stalls with data.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |-> !in.ready)
		else $error("input accepted while pipeline stalled");
	// A beat in the next-to-last stage reaches the last stage on an advance.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		vld[Rounds-1] && advance |=> out.valid)
		else $error("beat lost in the last stage");
endmodule
